// ----- sv/s2d_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
package s2d_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   // binary bits folded into the BCD register per conversion cycle
   localparam int BITS_PER_CYCLE = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture a new request
      logic step;      // run one conversion cycle
      logic next;      // advance to the next lower digit
      logic emit_sign; // present the minus sign
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done; // current conversion cycle is the last one
      logic neg;       // captured value is negative
      logic dig_last;  // pointing at the lowest digit
   } sts_type;

endpackage

// ----- sv/s2d_ctrl.sv -----
// Sequencer for capture, conversion and character emission.
module s2d_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output s2d_pkg::cmd_type  cmd,
   input  s2d_pkg::sts_type  sts
);

   s2d_pkg::state_type state_ff;
   s2d_pkg::state_type state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         s2d_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = s2d_pkg::ST_CONV;
         end
         s2d_pkg::ST_CONV: begin
            if (sts.conv_done) begin
               state_in = sts.neg ? s2d_pkg::ST_SIGN : s2d_pkg::ST_DIGIT;
            end
         end
         s2d_pkg::ST_SIGN: begin
            if (rsp_tready) state_in = s2d_pkg::ST_DIGIT;
         end
         s2d_pkg::ST_DIGIT: begin
            if (rsp_tready && sts.dig_last) state_in = s2d_pkg::ST_IDLE;
         end
      endcase
   end

   // drive handshakes and datapath commands
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.next      = 1'b0;
      cmd.emit_sign = 1'b0;
      unique case (state_ff)
         s2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         s2d_pkg::ST_CONV: begin
            cmd.step = 1'b1;
         end
         s2d_pkg::ST_SIGN: begin
            rsp_tvalid    = 1'b1;
            cmd.emit_sign = 1'b1;
         end
         s2d_pkg::ST_DIGIT: begin
            rsp_tvalid = 1'b1;
            cmd.next   = rsp_tready;
         end
      endcase
   end

endmodule

// ----- sv/s2d_dpath.sv -----
// Magnitude capture, shift-add-3 BCD conversion and digit selection.
module s2d_dpath #(
   parameter int VALUE_WIDTH = s2d_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] value,
   input  s2d_pkg::cmd_type       cmd,
   output s2d_pkg::sts_type       sts,
   output logic [7:0]             char_code,
   output logic                   is_last
);

   localparam int BPC   = s2d_pkg::BITS_PER_CYCLE;
   localparam int STEPS = (VALUE_WIDTH + BPC - 1) / BPC;
   localparam int PW    = STEPS * BPC;
   // enough decimal digits for a magnitude of 2^(VALUE_WIDTH-1)
   localparam int NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int IW    = $clog2(NDIG);
   localparam int CW    = $clog2(NDIG + 1);
   localparam int SW    = $clog2(STEPS);

   logic             neg_ff, neg_in;
   logic [PW-1:0]    bin_ff, bin_in, bin_v;
   logic [3:0]       dig_ff [NDIG];
   logic [3:0]       dig_in [NDIG];
   logic [3:0]       dig_v  [NDIG];
   logic [CW-1:0]    cnt_ff, cnt_in, cnt_v, cnt_dec;
   logic [SW-1:0]    step_ff, step_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] mag;

   assign mag     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
   assign cnt_dec = cnt_v - CW'(1);

   // fold BPC binary bits into the BCD digits, tracking the significant digit count
   always_comb begin
      dig_v = dig_ff;
      bin_v = bin_ff;
      cnt_v = cnt_ff;
      for (int s = 0; s < BPC; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (dig_v[d] >= 4'd5) dig_v[d] = dig_v[d] + 4'd3;
         end
         for (int d = NDIG - 1; d > 0; d--) begin
            dig_v[d] = {dig_v[d][2:0], dig_v[d-1][3]};
         end
         dig_v[0] = {dig_v[0][2:0], bin_v[PW-1]};
         bin_v    = {bin_v[PW-2:0], 1'b0};
         if (cnt_v < CW'(NDIG)) begin
            if (dig_v[cnt_v[IW-1:0]] != 4'd0) cnt_v = cnt_v + CW'(1);
         end
      end
   end

   // next register values
   always_comb begin
      neg_in  = neg_ff;
      bin_in  = bin_ff;
      dig_in  = dig_ff;
      cnt_in  = cnt_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      if (cmd.load) begin
         neg_in  = value[VALUE_WIDTH-1];
         bin_in  = PW'(mag);
         for (int d = 0; d < NDIG; d++) dig_in[d] = 4'd0;
         cnt_in  = CW'(1);
         step_in = '0;
      end else if (cmd.step) begin
         bin_in  = bin_v;
         dig_in  = dig_v;
         cnt_in  = cnt_v;
         step_in = step_ff + SW'(1);
         idx_in  = cnt_dec[IW-1:0];
      end else if (cmd.next) begin
         idx_in  = idx_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      dig_ff  <= dig_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
   end

   // status and character selection
   assign sts.conv_done = (step_ff == SW'(STEPS - 1));
   assign sts.neg       = neg_ff;
   assign sts.dig_last  = (idx_ff == '0);

   assign char_code = cmd.emit_sign ? s2d_pkg::CHAR_MINUS
                                    : s2d_pkg::CHAR_ZERO + {4'd0, dig_ff[idx_ff]};
   assign is_last   = !cmd.emit_sign && (idx_ff == '0);

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// Top level: signed integer in, decimal ASCII characters out.
//
// Request channel (req_): one signed integer per request in req_tdata.
// Response channel (rsp_): one ASCII character per response, most significant
// first; a negative value starts with '-', zero gives '0', no leading zeros.
// rsp_tlast marks the final character of each number.
// Per number: the request is taken, then shift-add-3 conversion runs (four
// bits per cycle), then the characters go out, one per cycle while rsp_tready
// is high. At 32 bits a number gives 1 to 11 characters; the next request is
// taken once the last character has gone.
// When the receiver holds rsp_tready low, the current character and its
// rsp_tlast hold until taken and no request is accepted meanwhile.
// Reset (synchronous, active high) returns the block to idle, ready for a
// request; a number in progress is dropped.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = s2d_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // [VALUE_WIDTH-1:0] value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [7:0] char_code
   output logic                                  rsp_tlast   // is_last
);

   s2d_pkg::cmd_type cmd;
   s2d_pkg::sts_type sts;

   s2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   s2d_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .char_code (rsp_tdata),
      .is_last   (rsp_tlast)
   );

   // one number at a time: never take a request while a character is offered
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   // an accepted request closes intake on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("intake still open after accepting a request");

   // only a minus sign or a decimal digit leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == s2d_pkg::CHAR_MINUS ||
                      (rsp_tdata >= s2d_pkg::CHAR_ZERO &&
                       rsp_tdata <= s2d_pkg::CHAR_ZERO + 8'd9)))
      else $error("response is not a sign or digit");

   // a minus sign is always followed by digits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == s2d_pkg::CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign marked as last character");

endmodule

// ----- tb/sv/signed_int_to_decimal_ascii_tb.sv -----
// Testbench for the signed integer to decimal ASCII converter: stream driver, predictor, checker.
module signed_int_to_decimal_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW            = s2d_pkg::VALUE_WIDTH_DEFAULT;
   localparam int DW            = ((VW + 7) / 8) * 8;
   localparam int RANDOM_PER_PH = 88;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 5000;
   localparam int MAX_REPORTS   = 40;

   // one expected character of a number's text
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   // Expected character stream, filled from each accepted request.
   class decimal_text_scoreboard;
      text_char_type expected_chars[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      function int pending_count();
         return expected_chars.size();
      endfunction

      // Append one expectation at the tail of the stream.
      function void add_expected(text_char_type ch);
         expected_chars = {expected_chars, ch};
      endfunction

      // Queue a minus sign for a negative value, then the magnitude's digits, most significant first.
      function void note_number(logic [VW-1:0] value);
         logic            neg;
         logic [VW-1:0]   mag;
         logic [7:0]      digits[$];
         text_char_type   ch;
         neg = value[VW-1];
         // two's complement wraps the most negative value onto 2^(VW-1)
         mag = neg ? (~value + 1'b1) : value;
         do begin
            digits.push_front(s2d_pkg::CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (neg) begin
            ch.code = s2d_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            add_expected(ch);
         end
         foreach (digits[i]) begin
            ch.code = digits[i];
            ch.last = (i == digits.size() - 1);
            add_expected(ch);
         end
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_char(logic [7:0] code, logic last);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                        $time, code, last);
            return;
         end
         want = expected_chars.pop_front();
         if (code !== want.code) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: char code mismatch: expected %0d, actual %0d",
                        $time, want.code, code);
         end
         if (last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: tlast mismatch: expected %0b, actual %0b",
                        $time, want.last, last);
         end
      endfunction
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata  = '0;  // [VW-1:0] value
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;        // [7:0] char_code
   logic          rsp_tlast;        // is_last

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_start     = 1'b0;

   decimal_text_scoreboard board;

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Note accepted requests first, then check accepted responses.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_number(req_tdata[VW-1:0]);
         if (rsp_tvalid && rsp_tready)
            board.check_char(rsp_tdata, rsp_tlast);
      end
   end

   // Pace the receiver; on request hold it off for a long stretch.
   initial begin : rsp_pacer
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // End the run when no request or response moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("signed_int_to_decimal_ascii_tb: errors");
      $finish;
   end

   // Offer one request, idling first at the current rate, and hold until taken.
   task automatic send_number(input logic [VW-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DW'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly numbers of a random digit count and sign, some raw 32-bit patterns.
   function automatic logic [VW-1:0] random_number();
      int unsigned     ndig;
      longint unsigned lim;
      logic [VW-1:0]   mag;
      if ($urandom_range(4) == 0)
         return VW'($urandom);
      ndig = $urandom_range(1, 10);
      lim  = 1;
      repeat (ndig) lim = lim * 10;
      lim = lim - 1;
      if (lim > 64'd2147483647)
         lim = 64'd2147483647;
      mag = VW'($urandom_range(32'(lim)));
      return $urandom_range(1) ? (~mag + 1'b1) : mag;
   endfunction

   // Directed corners, then four phases of random numbers under varied sender idling and receiver stalls.
   initial begin : stimulus
      logic [VW-1:0] corners[20];
      corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                  32'd999999999, -32'sd999999999, 32'd123456789, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'd42, -32'sd7, 32'd1999999999};
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (phase == 0) begin
            foreach (corners[i]) send_number(corners[i]);
            // stall the receiver while requests keep coming
            hold_start = 1'b1;
         end
         repeat (RANDOM_PER_PH) send_number(random_number());
         req_tvalid <= 1'b0;
         // let the checker note the last request before draining
         @(posedge clock);
         while (board.pending_count() != 0) @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_count() == 0)
         $display("signed_int_to_decimal_ascii_tb: clean");
      else
         $display("signed_int_to_decimal_ascii_tb: errors");
      $finish;
   end

endmodule

// ----- files.f -----
sv/s2d_pkg.sv
sv/s2d_ctrl.sv
sv/s2d_dpath.sv
sv/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
